>>> hdl/hhfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhfe_pkg
// Shared types, codes and keyword tables of the HTTP header field extractor.
// ----------------------------------------------------------------------------
package hhfe_pkg;

  // Input actions
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_VALUE  = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Field identifiers
  localparam logic [2:0] FLD_HOST   = 3'd0;
  localparam logic [2:0] FLD_PORT   = 3'd1;
  localparam logic [2:0] FLD_ACCEPT = 3'd2;
  localparam logic [2:0] FLD_GET    = 3'd3;
  localparam logic [2:0] FLD_POST   = 3'd4;

  // Header end status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;
  localparam logic [1:0] ST_CLOSED   = 2'd3;

  // Register indexes (byte address bit 2)
  localparam logic REG_MAX_LINE_LENGTH  = 1'b0;
  localparam logic REG_MAX_HEADER_LINES = 1'b1;

  localparam logic [12:0] MAX_LINE_LENGTH_RST  = 13'd1024;
  localparam logic [7:0]  MAX_HEADER_LINES_RST = 8'd100;

  // Position of the first Accept value byte in its line
  localparam logic [12:0] ACCEPT_VALUE_POS = 13'd7;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_COLON = 8'h3A;

  typedef enum logic [3:0] {
    CLS_START       = 4'd0,
    CLS_PART_GET    = 4'd1,
    CLS_PART_POST   = 4'd2,
    CLS_PART_HOST   = 4'd3,
    CLS_PART_ACCEPT = 4'd4,
    CLS_GET         = 4'd5,
    CLS_POST        = 4'd6,
    CLS_HOST        = 4'd7,
    CLS_ACCEPT      = 4'd8,
    CLS_OTHER       = 4'd15
  } line_class_t;

  typedef enum logic [1:0] {
    HP_SKIP = 2'd0,
    HP_NAME = 2'd1,
    HP_PORT = 2'd2
  } host_phase_t;

  // Keyword index: 0 GET, 1 POST, 2 Host:, 3 Accept:
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    unique case (k)
      2'd0:    len = 3'd3;
      2'd1:    len = 3'd4;
      2'd2:    len = 3'd5;
      default: len = 3'd7;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (pos)
          3'd0:    ch = "G";
          3'd1:    ch = "E";
          3'd2:    ch = "T";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (pos)
          3'd0:    ch = "P";
          3'd1:    ch = "O";
          3'd2:    ch = "S";
          3'd3:    ch = "T";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (pos)
          3'd0:    ch = "H";
          3'd1:    ch = "o";
          3'd2:    ch = "s";
          3'd3:    ch = "t";
          3'd4:    ch = ":";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0:    ch = "A";
          3'd1:    ch = "c";
          3'd2:    ch = "c";
          3'd3:    ch = "e";
          3'd4:    ch = "p";
          3'd5:    ch = "t";
          3'd6:    ch = ":";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic line_class_t kw_full_class(input logic [1:0] k);
    line_class_t cls;
    unique case (k)
      2'd0:    cls = CLS_GET;
      2'd1:    cls = CLS_POST;
      2'd2:    cls = CLS_HOST;
      default: cls = CLS_ACCEPT;
    endcase
    return cls;
  endfunction

  function automatic line_class_t first_class(input logic [7:0] c);
    line_class_t cls;
    priority if (c == "G") cls = CLS_PART_GET;
    else if (c == "P")     cls = CLS_PART_POST;
    else if (c == "H")     cls = CLS_PART_HOST;
    else if (c == "A")     cls = CLS_PART_ACCEPT;
    else                   cls = CLS_OTHER;
    return cls;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

>>> hdl/hhfe_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhfe_stream_if
// Valid/ready channels carrying header bytes in and extracted items out.
// ----------------------------------------------------------------------------
interface hhfe_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink   (input valid, input action, input byte_value, output ready);
endinterface

interface hhfe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [2:0] field_id;
  logic [7:0] value_byte;
  logic       first_of_value;
  logic [1:0] status;
  logic [7:0] line_count;

  modport source (output valid, output item_kind, output field_id, output value_byte,
                  output first_of_value, output status, output line_count, input ready);
  modport sink   (input valid, input item_kind, input field_id, input value_byte,
                  input first_of_value, input status, input line_count, output ready);
endinterface

>>> hdl/http_header_field_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_field_extractor
// Byte-wise HTTP request header parser that streams Host, port and Accept
// values and reports line commits and header end.
// ----------------------------------------------------------------------------
// Each request on hdr_in carries one header byte or a connection-closed event;
// a new request can be accepted every clock while hdr_out does not stall.
// The line state (length, prefix class, host phase and counters) is updated
// at acceptance, and the zero or one item it causes lands in the output
// register in the next cycle. hdr_in.ready is high whenever that register is
// empty or is being drained in the same cycle, so a full-rate stream passes
// with no bubbles and only a stall on hdr_out holds the input back.
// Registers sit on an APB port: max_line_length at byte address 0 and
// max_header_lines at 4; write them only while no request is in flight.
// Every header end clears the parse state, so the next byte opens a new header.
// ----------------------------------------------------------------------------
module http_header_field_extractor
  import hhfe_pkg::*;
#(
  parameter int HOST_CAP = 15,
  parameter int PORT_CAP = 5
) (
  input  logic        clk,
  input  logic        rst,
  hhfe_in_if.sink     hdr_in,
  hhfe_out_if.source  hdr_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int HCW = $clog2(HOST_CAP + 1);
  localparam int PCW = $clog2(PORT_CAP + 1);

  // Configuration registers
  logic [12:0] max_line_length;
  logic [7:0]  max_header_lines;

  // Parse state
  logic [12:0]  line_length, line_length_next;
  logic [7:0]   header_lines, header_lines_next;
  logic         after_cr, after_cr_next;
  line_class_t  line_class, line_class_next;
  host_phase_t  host_phase, host_phase_next;
  logic [HCW-1:0] host_chars, host_chars_next;
  logic [PCW-1:0] port_chars, port_chars_next;

  // Output register
  logic       out_valid;
  logic [1:0] out_kind;
  logic [2:0] out_field;
  logic [7:0] out_byte;
  logic       out_first;
  logic [1:0] out_status;
  logic [7:0] out_count;

  // Result of the request being accepted
  logic       res_valid;
  logic [1:0] res_kind;
  logic [2:0] res_field;
  logic [7:0] res_byte;
  logic       res_first;
  logic [1:0] res_status;
  logic [7:0] res_count;

  logic        in_acc;
  logic        end_req;
  logic [1:0]  end_status;
  logic [7:0]  end_count;
  logic [7:0]  lb;
  logic [12:0] len_inc;
  logic [7:0]  hl_inc;
  logic [1:0]  kw_idx;
  logic [3:0]  cls_bits;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // Take a new request while the output register is empty or draining
  assign hdr_in.ready = !out_valid || hdr_out.ready;
  assign in_acc       = hdr_in.valid && hdr_in.ready;

  always_comb begin
    unique case (paddr[2])
      REG_MAX_LINE_LENGTH:  prdata = {19'd0, max_line_length};
      default:              prdata = {24'd0, max_header_lines};
    endcase
  end

  always_comb begin
    line_length_next  = line_length;
    header_lines_next = header_lines;
    after_cr_next     = after_cr;
    line_class_next   = line_class;
    host_phase_next   = host_phase;
    host_chars_next   = host_chars;
    port_chars_next   = port_chars;

    res_valid  = 1'b0;
    res_kind   = KIND_VALUE;
    res_field  = FLD_HOST;
    res_byte   = 8'd0;
    res_first  = 1'b0;
    res_status = ST_OK;
    res_count  = 8'd0;

    end_req    = 1'b0;
    end_status = ST_OK;
    end_count  = header_lines;

    // A pending CR that is not followed by LF becomes a line byte itself,
    // and the byte that broke the pair is dropped.
    lb       = after_cr ? CHR_CR : hdr_in.byte_value;
    len_inc  = line_length + 13'd1;
    hl_inc   = header_lines + 8'd1;
    cls_bits = line_class;
    kw_idx   = cls_bits[1:0] - 2'd1;

    if (in_acc) begin
      if (hdr_in.action == ACT_CLOSE) begin
        // Close right after CR ends cleanly; the pending line is discarded
        end_req    = 1'b1;
        end_status = after_cr ? ST_OK : ST_CLOSED;
      end else if (after_cr && hdr_in.byte_value == CHR_LF) begin
        after_cr_next = 1'b0;
        if (line_length == 13'd0) begin
          // Empty line closes the header
          end_req    = 1'b1;
          end_status = ST_OK;
        end else if (hl_inc >= max_header_lines) begin
          end_req    = 1'b1;
          end_status = ST_TOO_MANY;
          end_count  = hl_inc;
        end else begin
          header_lines_next = hl_inc;
          line_length_next  = 13'd0;
          line_class_next   = CLS_START;
          host_phase_next   = HP_SKIP;
          host_chars_next   = '0;
          port_chars_next   = '0;
          res_kind          = KIND_COMMIT;
          unique case (line_class)
            CLS_GET: begin
              res_valid = 1'b1;
              res_field = FLD_GET;
            end
            CLS_POST: begin
              res_valid = 1'b1;
              res_field = FLD_POST;
            end
            CLS_HOST: begin
              res_valid = 1'b1;
              res_field = FLD_HOST;
            end
            CLS_ACCEPT: begin
              res_valid = 1'b1;
              res_field = FLD_ACCEPT;
            end
            default: res_valid = 1'b0;
          endcase
        end
      end else if (!after_cr && hdr_in.byte_value == CHR_CR) begin
        // Hold the CR until the next byte tells whether it ends the line
        after_cr_next = 1'b1;
      end else begin
        after_cr_next    = 1'b0;
        line_length_next = len_inc;
        if (len_inc >= max_line_length) begin
          end_req    = 1'b1;
          end_status = ST_TOO_LONG;
        end else begin
          unique case (line_class)
            CLS_HOST: begin
              if (host_phase == HP_SKIP && is_space(lb)) begin
                // drop leading whitespace
              end else if (host_phase != HP_PORT) begin
                if (lb == CHR_COLON) begin
                  host_phase_next = HP_PORT;
                end else begin
                  host_phase_next = HP_NAME;
                  if (host_chars < HCW'(HOST_CAP)) begin
                    res_valid       = 1'b1;
                    res_field       = FLD_HOST;
                    res_byte        = lb;
                    res_first       = (host_chars == '0);
                    host_chars_next = host_chars + HCW'(1);
                  end
                end
              end else if (port_chars < PCW'(PORT_CAP)) begin
                res_valid       = 1'b1;
                res_field       = FLD_PORT;
                res_byte        = lb;
                res_first       = (port_chars == '0);
                port_chars_next = port_chars + PCW'(1);
              end
            end
            CLS_ACCEPT: begin
              res_valid = 1'b1;
              res_field = FLD_ACCEPT;
              res_byte  = lb;
              res_first = (line_length == ACCEPT_VALUE_POS);
            end
            CLS_START: line_class_next = first_class(lb);
            CLS_PART_GET, CLS_PART_POST, CLS_PART_HOST, CLS_PART_ACCEPT: begin
              // Advance the prefix match, or drop to unclassified on mismatch
              if (line_length < 13'(kw_len(kw_idx)) &&
                  kw_char(kw_idx, line_length[2:0]) == lb) begin
                if (len_inc == 13'(kw_len(kw_idx))) begin
                  line_class_next = kw_full_class(kw_idx);
                end
              end else begin
                line_class_next = CLS_OTHER;
              end
            end
            default: line_class_next = line_class;
          endcase
        end
      end
    end

    // A header end wins over any other result and restarts the parse
    if (end_req) begin
      line_length_next  = 13'd0;
      header_lines_next = 8'd0;
      after_cr_next     = 1'b0;
      line_class_next   = CLS_START;
      host_phase_next   = HP_SKIP;
      host_chars_next   = '0;
      port_chars_next   = '0;
      res_valid         = 1'b1;
      res_kind          = KIND_END;
      res_field         = FLD_HOST;
      res_byte          = 8'd0;
      res_first         = 1'b0;
      res_status        = end_status;
      res_count         = end_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length  <= MAX_LINE_LENGTH_RST;
      max_header_lines <= MAX_HEADER_LINES_RST;
      line_length      <= 13'd0;
      header_lines     <= 8'd0;
      after_cr         <= 1'b0;
      line_class       <= CLS_START;
      host_phase       <= HP_SKIP;
      host_chars       <= '0;
      port_chars       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_MAX_LINE_LENGTH:  max_line_length  <= pwdata[12:0];
          default:              max_header_lines <= pwdata[7:0];
        endcase
      end
      line_length  <= line_length_next;
      header_lines <= header_lines_next;
      after_cr     <= after_cr_next;
      line_class   <= line_class_next;
      host_phase   <= host_phase_next;
      host_chars   <= host_chars_next;
      port_chars   <= port_chars_next;
      if (in_acc) begin
        out_valid <= res_valid;
      end else if (hdr_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the payload only when a new result is captured
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_kind   <= res_kind;
      out_field  <= res_field;
      out_byte   <= res_byte;
      out_first  <= res_first;
      out_status <= res_status;
      out_count  <= res_count;
    end
  end

  assign hdr_out.valid          = out_valid;
  assign hdr_out.item_kind      = out_kind;
  assign hdr_out.field_id       = out_field;
  assign hdr_out.value_byte     = out_byte;
  assign hdr_out.first_of_value = out_first;
  assign hdr_out.status         = out_status;
  assign hdr_out.line_count     = out_count;

endmodule

>>> hdl/hhfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhfe_checker
// Port-level checks on the extractor's output stream.
// ----------------------------------------------------------------------------
module hhfe_checker
  import hhfe_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] item_kind,
  input logic [2:0] field_id,
  input logic [7:0] value_byte,
  input logic       first_of_value,
  input logic [1:0] status,
  input logic [7:0] line_count
);

  // Hold a stalled item unchanged
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(field_id) &&
      $stable(value_byte) && $stable(first_of_value) && $stable(status) &&
      $stable(line_count))
    else $error("output item changed while stalled");

  // Drop any pending item on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_end_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_END |->
      field_id == FLD_HOST && value_byte == 8'd0 && !first_of_value)
    else $error("header end item carries field data");

  a_value_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_VALUE |->
      (field_id == FLD_HOST || field_id == FLD_PORT || field_id == FLD_ACCEPT) &&
      status == ST_OK && line_count == 8'd0)
    else $error("value item with bad field or status");

  a_commit_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_COMMIT |->
      field_id != FLD_PORT && value_byte == 8'd0 && !first_of_value &&
      status == ST_OK && line_count == 8'd0)
    else $error("commit item malformed");

endmodule

bind http_header_field_extractor hhfe_checker u_hhfe_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (hdr_out.valid),
  .out_ready      (hdr_out.ready),
  .item_kind      (hdr_out.item_kind),
  .field_id       (hdr_out.field_id),
  .value_byte     (hdr_out.value_byte),
  .first_of_value (hdr_out.first_of_value),
  .status         (hdr_out.status),
  .line_count     (hdr_out.line_count)
);

>>> tb/tb_http_header_field_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_header_field_extractor
// Self-checking bench for the HTTP header field extractor: a short directed
// run, then random headers under several limit settings, with random idling
// and a long output stall, each output item checked against a local model.
// ----------------------------------------------------------------------------
module tb_http_header_field_extractor;
  import hhfe_pkg::*;

  localparam int HOST_CAP    = 15;
  localparam int PORT_CAP    = 5;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 115;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 1000;

  // One request on the input channel
  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } hdr_req_t;

  // One item on the output channel
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] field_id;
    logic [7:0] value;
    logic       first;
    logic [1:0] status;
    logic [7:0] count;
  } hdr_item_t;

  // --------------------------------------------------------------------------
  // Line parser model plus the queue of items it predicts
  // --------------------------------------------------------------------------
  class field_scoreboard;
    logic [12:0] max_line_len;
    logic [7:0]  max_lines;
    logic [12:0] line_len;
    logic [7:0]  line_total;
    logic        cr_pending;
    line_class_t cls;
    host_phase_t hphase;
    logic [3:0]  host_cnt;
    logic [2:0]  port_cnt;
    string       kw[4];
    hdr_item_t   expected_items[$];
    int          errors;

    function new();
      kw           = '{"GET", "POST", "Host:", "Accept:"};
      max_line_len = MAX_LINE_LENGTH_RST;
      max_lines    = MAX_HEADER_LINES_RST;
      line_total   = '0;
      errors       = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len   = '0;
      cr_pending = 1'b0;
      cls        = CLS_START;
      hphase     = HP_SKIP;
      host_cnt   = '0;
      port_cnt   = '0;
    endfunction

    function void push_item(logic [1:0] kind, logic [2:0] fld, logic [7:0] val,
                            logic first, logic [1:0] st, logic [7:0] cnt);
      expected_items.push_back(hdr_item_t'{kind, fld, val, first, st, cnt});
    endfunction

    // Report header end with the lines counted so far, then start over
    function void finish_header(logic [1:0] st);
      push_item(KIND_END, FLD_HOST, 8'h00, 1'b0, st, line_total);
      clear_line();
      line_total = '0;
    endfunction

    function void line_char(logic [7:0] c);
      logic [12:0] pos;
      int          k;
      pos      = line_len;
      line_len = pos + 13'd1;
      if (line_len >= max_line_len) begin
        finish_header(ST_TOO_LONG);
        return;
      end
      case (cls)
        CLS_HOST: begin
          if (hphase == HP_SKIP && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)))
            return;
          if (hphase != HP_PORT) begin
            if (c == CHR_COLON) begin
              hphase = HP_PORT;
              return;
            end
            hphase = HP_NAME;
            if (host_cnt < HOST_CAP) begin
              push_item(KIND_VALUE, FLD_HOST, c, host_cnt == 0, ST_OK, 8'h00);
              host_cnt++;
            end
          end else if (port_cnt < PORT_CAP) begin
            push_item(KIND_VALUE, FLD_PORT, c, port_cnt == 0, ST_OK, 8'h00);
            port_cnt++;
          end
        end
        CLS_ACCEPT: begin
          push_item(KIND_VALUE, FLD_ACCEPT, c, pos == ACCEPT_VALUE_POS, ST_OK, 8'h00);
        end
        CLS_START: begin
          cls = CLS_OTHER;
          for (k = 0; k < 4; k++)
            if (c == kw[k][0]) cls = line_class_t'(k + 1);
        end
        CLS_PART_GET, CLS_PART_POST, CLS_PART_HOST, CLS_PART_ACCEPT: begin
          k = int'(cls) - 1;
          if (pos < kw[k].len() && c == kw[k][pos]) begin
            if (pos + 1 == kw[k].len()) cls = line_class_t'(k + 5);
          end else begin
            cls = CLS_OTHER;
          end
        end
        default: ;
      endcase
    endfunction

    function void line_break();
      line_class_t done_cls;
      done_cls = cls;
      if (line_len == 0) begin
        finish_header(ST_OK);
        return;
      end
      line_total++;
      if (line_total >= max_lines) begin
        finish_header(ST_TOO_MANY);
        return;
      end
      clear_line();
      case (done_cls)
        CLS_GET:    push_item(KIND_COMMIT, FLD_GET, 8'h00, 1'b0, ST_OK, 8'h00);
        CLS_POST:   push_item(KIND_COMMIT, FLD_POST, 8'h00, 1'b0, ST_OK, 8'h00);
        CLS_HOST:   push_item(KIND_COMMIT, FLD_HOST, 8'h00, 1'b0, ST_OK, 8'h00);
        CLS_ACCEPT: push_item(KIND_COMMIT, FLD_ACCEPT, 8'h00, 1'b0, ST_OK, 8'h00);
        default: ;
      endcase
    endfunction

    function void note_request(logic act, logic [7:0] c);
      if (act == ACT_CLOSE) begin
        finish_header(cr_pending ? ST_OK : ST_CLOSED);
      end else if (cr_pending) begin
        // a CR not followed by LF is a line byte; the byte after it is lost
        cr_pending = 1'b0;
        if (c == CHR_LF) line_break();
        else line_char(CHR_CR);
      end else if (c == CHR_CR) begin
        cr_pending = 1'b1;
      end else begin
        line_char(c);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_item(hdr_item_t got);
      hdr_item_t want;
      if (expected_items.size() == 0) begin
        $error("unexpected item: kind %0d field %0d value %0d status %0d",
               got.kind, got.field_id, got.value, got.status);
        errors++;
        return;
      end
      want = expected_items.pop_front();
      check_field("item_kind", want.kind, got.kind);
      check_field("field_id", want.field_id, got.field_id);
      check_field("value_byte", want.value, got.value);
      check_field("first_of_value", want.first, got.first);
      check_field("status", want.status, got.status);
      check_field("line_count", want.count, got.count);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hhfe_in_if  in_bus();
  hhfe_out_if out_bus();

  http_header_field_extractor dut (
    .clk     (clk),
    .rst     (rst),
    .hdr_in  (in_bus),
    .hdr_out (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  field_scoreboard field_check = new();

  hdr_req_t stim_q[$];
  bit       no_idle;       // both sides run without gaps while set
  bit       hold_request;  // ask the receiver for one long stall

  // Limits per phase; phase 0 keeps the reset values
  logic [12:0] line_limits[PHASES] = '{13'd1024, 13'd2, 13'd4096, 13'd20,
                                       13'd8191, 13'd48, 13'd1};
  logic [7:0]  line_caps[PHASES]   = '{8'd100, 8'd1, 8'd255, 8'd4, 8'd255, 8'd6, 8'd0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request builders: append to stim_q
  // --------------------------------------------------------------------------
  function automatic void add_data(logic [7:0] c);
    stim_q.push_back(hdr_req_t'{ACT_DATA, c});
  endfunction

  function automatic void add_close();
    stim_q.push_back(hdr_req_t'{ACT_CLOSE, 8'($urandom_range(0, 255))});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_data(s[i]);
  endfunction

  function automatic void add_crlf();
    add_data(CHR_CR);
    add_data(CHR_LF);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(33, 126));
  endfunction

  // One line body without its CRLF; mostly well-formed header lines
  function automatic void build_line();
    string kw_pick;
    case ($urandom_range(0, 9))
      0: begin
        add_text("GET /");
        repeat ($urandom_range(0, 4)) add_data(printable());
      end
      1: begin
        add_text("POST /");
        repeat ($urandom_range(0, 4)) add_data(printable());
      end
      2, 3: begin
        add_text("Host:");
        // leading whitespace that the host skip drops
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 4))
            0: add_data(8'h20);
            1: add_data(8'h09);
            2: add_data(8'h0A);
            3: add_data(8'h0B);
            default: add_data(8'h0C);
          endcase
        end
        repeat ($urandom_range(0, 18)) add_data(printable());
        if ($urandom_range(0, 1)) begin
          add_data(CHR_COLON);
          repeat ($urandom_range(0, 7)) add_data(8'($urandom_range(48, 57)));
        end
      end
      4, 5: begin
        add_text("Accept:");
        repeat ($urandom_range(0, 10)) add_data(8'($urandom_range(0, 255)));
      end
      6: begin
        // keyword cut short, then anything
        case ($urandom_range(0, 3))
          0: kw_pick = "GET";
          1: kw_pick = "POST";
          2: kw_pick = "Host:";
          default: kw_pick = "Accept:";
        endcase
        add_text(kw_pick.substr(0, $urandom_range(0, kw_pick.len() - 2)));
        add_data(printable());
      end
      7: repeat ($urandom_range(1, 8)) add_data(8'($urandom_range(0, 255)));
      default: repeat ($urandom_range(1, 10)) add_data(printable());
    endcase
    // bare CR now and then; the byte after it gets dropped
    if ($urandom_range(0, 11) == 0) begin
      add_data(CHR_CR);
      add_data(printable());
    end
  endfunction

  function automatic void build_header();
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes with the odd close
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 15) == 0) add_close();
        else add_data(8'($urandom_range(0, 255)));
      end
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      build_line();
      add_crlf();
    end
    case ($urandom_range(0, 9))
      0: begin
        add_data(CHR_CR);
        add_close();
      end
      1: add_close();
      2: begin
        build_line();
        add_close();
      end
      3: ;  // no terminator: the next header runs on
      default: add_crlf();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one request; entered and left at a falling edge
  task automatic send_request(input hdr_req_t req);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.action     <= req.action;
    in_bus.byte_value <= req.byte_value;
    do @(posedge clk); while (!in_bus.ready);
    field_check.note_request(req.action, req.byte_value);
    @(negedge clk);
  endtask

  task automatic send_all();
    foreach (stim_q[i]) send_request(stim_q[i]);
    stim_q.delete();
  endtask

  // Drop valid and hold until every predicted item has come out
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (field_check.expected_items.size() != 0);
  endtask

  // APB write, then read back the same register
  task automatic write_register(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MAX_LINE_LENGTH) begin
      field_check.max_line_len = value[12:0];
      want = {19'd0, value[12:0]};
    end else begin
      field_check.max_lines = value[7:0];
      want = {24'd0, value[7:0]};
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback != want) begin
      $error("prdata: expected %0d, got %0d", want, readback);
      field_check.errors++;
    end
  endtask

  task automatic set_limits(input logic [12:0] line_limit, input logic [7:0] line_cap);
    wait_drained();
    // a request with no item may still be in flight; give it time to settle
    repeat (4) @(negedge clk);
    write_register(REG_MAX_LINE_LENGTH, {19'd0, line_limit});
    write_register(REG_MAX_HEADER_LINES, {24'd0, line_cap});
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, with one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // hold ready low so the output register fills and stalls the input
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_bus.ready <= no_idle || ($urandom_range(99) >= 37);
      end
    end
  end

  // Check every item taken from the output channel
  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready)
      field_check.check_item(hdr_item_t'{out_bus.item_kind, out_bus.field_id,
                                         out_bus.value_byte, out_bus.first_of_value,
                                         out_bus.status, out_bus.line_count});
  end

  // Advance a count of cycles with no handshake on either side; drop out at the limit
  initial begin : watchdog
    int quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int sent;
    rst               <= 1'b1;
    in_bus.valid      <= 1'b0;
    in_bus.action     <= ACT_DATA;
    in_bus.byte_value <= 8'h00;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: close before any byte, a GET line, a host with port,
    // a bare CR, close right after CR, then byte extremes closed early
    add_close();
    add_text("GET");
    add_crlf();
    add_text("Host: a:9");
    add_crlf();
    add_data(CHR_CR);
    add_data("z");
    add_data(CHR_CR);
    add_close();
    add_data(8'hFF);
    add_data(8'h00);
    add_close();
    send_all();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) set_limits(line_limits[p], line_caps[p]);
      no_idle = (p == 2);
      if (p == 4) hold_request = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_header();
        sent += stim_q.size();
        send_all();
        // now and then let the output run dry before the next header
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (field_check.errors == 0 && field_check.expected_items.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
hdl/hhfe_pkg.sv
hdl/hhfe_stream_if.sv
hdl/http_header_field_extractor.sv
hdl/hhfe_checker.sv
tb/tb_http_header_field_extractor.sv
